[src/tls_pkg.sv]
// Shared types and constants for the traffic light sequencer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package tls_pkg;

  localparam int NumRegs   = 8;
  localparam int LenW      = 7;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;

  localparam logic [LenW-1:0] MaxCount = 7'd99;

  // Register indexes
  localparam logic [2:0] RegGreenNormal  = 3'd0;
  localparam logic [2:0] RegGreenSensor  = 3'd1;
  localparam logic [2:0] RegGreenRequest = 3'd2;
  localparam logic [2:0] RegAmberNormal  = 3'd3;
  localparam logic [2:0] RegRequestHold  = 3'd4;
  localparam logic [2:0] RegRedNormal    = 3'd5;
  localparam logic [2:0] RegRedSensor    = 3'd6;
  localparam logic [2:0] RegRedRequest   = 3'd7;

  // Phase codes
  localparam logic [2:0] PhStart    = 3'd0;
  localparam logic [2:0] PhGreen    = 3'd1;
  localparam logic [2:0] PhAmber    = 3'd2;
  localparam logic [2:0] PhRed      = 3'd3;
  localparam logic [2:0] PhReqLead  = 3'd4;
  localparam logic [2:0] PhReqGreen = 3'd5;
  localparam logic [2:0] PhReqAmber = 3'd6;
  localparam logic [2:0] PhReqRed   = 3'd7;

  // Lamp codes
  localparam logic [1:0] LampGreen = 2'd0;
  localparam logic [1:0] LampAmber = 2'd1;
  localparam logic [1:0] LampRed   = 2'd2;

  typedef logic [LenW-1:0] len_t;
  typedef len_t [NumRegs-1:0] cfg_t;

  typedef struct packed {
    logic sensor_level;
    logic request_edge;
  } in_t;

  typedef struct packed {
    logic [1:0] lamp;
    logic       cross_line;
    logic [3:0] count_tens;
    logic [3:0] count_units;
    logic       serving_request;
  } out_t;

  // Next phase and count handed from the sequencer to the display stage
  typedef struct packed {
    logic       load;
    logic [2:0] phase;
    len_t       remaining;
  } seq_view_t;

endpackage
`default_nettype wire

[src/traffic_light_sequencer.sv]
// Traffic light sequencer top level: config registers, sequencer, display.
// Latency: a result appears in the cycle after its tick request is accepted.
// Throughput: one request per cycle; input is taken whenever the result
// register is empty or being drained in the same cycle.
// Reset: synchronous, active high; restores register defaults, clears sequencer state and out_valid.
// Depends on tls_pkg, tls_regs, tls_seq, tls_disp.
`default_nettype none
module traffic_light_sequencer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tls_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tls_pkg::out_t                  out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tls_pkg::AddrW-1:0] paddr,
  input  wire logic [tls_pkg::DataW-1:0] pwdata,
  output logic      [tls_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  tls_pkg::cfg_t      cfg;
  tls_pkg::seq_view_t view;
  logic               accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tls_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg),
    .view    (view)
  );

  tls_disp u_disp (
    .clk       (clk),
    .rst       (rst),
    .view      (view),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[src/tls_regs.sv]
// APB-style configuration registers holding the phase lengths.
// Depends on tls_pkg.
`default_nettype none
module tls_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tls_pkg::AddrW-1:0] paddr,
  input  wire logic [tls_pkg::DataW-1:0] pwdata,
  output logic      [tls_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output tls_pkg::cfg_t                  cfg
);

  tls_pkg::cfg_t regs;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[tls_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;
  assign prdata = {{(tls_pkg::DataW - tls_pkg::LenW){1'b0}}, regs[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[tls_pkg::RegGreenNormal]  <= 7'd30;
      regs[tls_pkg::RegGreenSensor]  <= 7'd66;
      regs[tls_pkg::RegGreenRequest] <= 7'd66;
      regs[tls_pkg::RegAmberNormal]  <= 7'd3;
      regs[tls_pkg::RegRequestHold]  <= 7'd8;
      regs[tls_pkg::RegRedNormal]    <= 7'd20;
      regs[tls_pkg::RegRedSensor]    <= 7'd30;
      regs[tls_pkg::RegRedRequest]   <= 7'd30;
    end else if (wr_en) begin
      regs[idx] <= pwdata[tls_pkg::LenW-1:0];
    end
  end

endmodule
`default_nettype wire

[src/tls_seq.sv]
// Phase sequencer: normal cycle, request preemption and countdown.
// Depends on tls_pkg.
`default_nettype none
module tls_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire tls_pkg::in_t  in_data,
  input  wire tls_pkg::cfg_t cfg,
  output tls_pkg::seq_view_t view
);

  logic [2:0]    phase, phase_next;
  tls_pkg::len_t remaining, remaining_next;
  logic          long_mode, long_mode_next;
  logic [1:0]    resume_phase, resume_phase_next;
  logic          dec;
  logic [2:0]    sel;
  tls_pkg::len_t raw_len, len;

  // Pick the length register for the phase being entered
  always_comb begin
    unique case (phase_next)
      tls_pkg::PhGreen:
        sel = long_mode_next ? tls_pkg::RegGreenSensor : tls_pkg::RegGreenNormal;
      tls_pkg::PhAmber:    sel = tls_pkg::RegAmberNormal;
      tls_pkg::PhRed:
        sel = long_mode_next ? tls_pkg::RegRedSensor : tls_pkg::RegRedNormal;
      tls_pkg::PhReqLead:  sel = tls_pkg::RegRequestHold;
      tls_pkg::PhReqGreen: sel = tls_pkg::RegGreenRequest;
      tls_pkg::PhReqAmber: sel = tls_pkg::RegRequestHold;
      default:             sel = tls_pkg::RegRedRequest;
    endcase
    raw_len = cfg[sel];
    if (raw_len == '0) begin
      len = 7'd1;
    end else if (raw_len > tls_pkg::MaxCount) begin
      len = tls_pkg::MaxCount;
    end else begin
      len = raw_len;
    end
  end

  always_comb begin
    phase_next        = phase;
    long_mode_next    = long_mode;
    resume_phase_next = resume_phase;
    dec               = 1'b0;
    if (in_data.request_edge && !phase[2]) begin
      phase_next = (phase == tls_pkg::PhRed) ? tls_pkg::PhReqLead : tls_pkg::PhReqGreen;
      if (phase == tls_pkg::PhGreen) begin
        resume_phase_next = tls_pkg::PhAmber[1:0];
      end else if (phase == tls_pkg::PhAmber) begin
        resume_phase_next = tls_pkg::PhRed[1:0];
      end else begin
        resume_phase_next = tls_pkg::PhStart[1:0];
      end
    end else if (phase == tls_pkg::PhStart) begin
      long_mode_next = in_data.sensor_level;
      phase_next     = tls_pkg::PhGreen;
    end else if (remaining > 7'd1) begin
      dec = 1'b1;
    end else begin
      unique case (phase)
        tls_pkg::PhGreen:    phase_next = tls_pkg::PhAmber;
        tls_pkg::PhAmber:    phase_next = tls_pkg::PhRed;
        tls_pkg::PhReqLead:  phase_next = tls_pkg::PhReqGreen;
        tls_pkg::PhReqGreen: phase_next = tls_pkg::PhReqAmber;
        tls_pkg::PhReqAmber: phase_next = tls_pkg::PhReqRed;
        tls_pkg::PhReqRed: begin
          if (resume_phase == tls_pkg::PhAmber[1:0] ||
              resume_phase == tls_pkg::PhRed[1:0]) begin
            phase_next = {1'b0, resume_phase};
          end else begin
            long_mode_next = in_data.sensor_level;
            phase_next     = tls_pkg::PhGreen;
          end
        end
        default: begin
          // end of red: new cycle start
          long_mode_next = in_data.sensor_level;
          phase_next     = tls_pkg::PhGreen;
        end
      endcase
    end
  end

  assign remaining_next = dec ? remaining - 7'd1 : len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tls_pkg::PhStart;
      remaining    <= '0;
      long_mode    <= 1'b0;
      resume_phase <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      long_mode    <= long_mode_next;
      resume_phase <= resume_phase_next;
    end
  end

  assign view.load      = accept;
  assign view.phase     = phase_next;
  assign view.remaining = remaining_next;

endmodule
`default_nettype wire

[src/tls_disp.sv]
// Display stage: lamp decode, BCD split and the result register.
// Depends on tls_pkg.
`default_nettype none
module tls_disp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tls_pkg::seq_view_t view,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output tls_pkg::out_t           out_data
);

  logic [14:0]   prod;
  logic [3:0]    tens;
  tls_pkg::len_t tens_x10;
  tls_pkg::len_t units;
  logic [1:0]    lamp;
  tls_pkg::out_t res;

  // tens = floor(v / 10) for v up to 99 via multiply by 205, shift by 11
  assign prod     = {8'd0, view.remaining} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign units    = view.remaining - tens_x10;

  always_comb begin
    case (view.phase)
      tls_pkg::PhGreen, tls_pkg::PhReqGreen: lamp = tls_pkg::LampGreen;
      tls_pkg::PhAmber, tls_pkg::PhReqAmber: lamp = tls_pkg::LampAmber;
      default:                               lamp = tls_pkg::LampRed;
    endcase
    res.lamp            = lamp;
    res.cross_line      = (lamp != tls_pkg::LampRed);
    res.count_tens      = tens;
    res.count_units     = units[3:0];
    res.serving_request = view.phase[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (view.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (view.load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

[src/tls_checker.sv]
// Port-level checks for the traffic light sequencer, bound to the top level.
// Depends on tls_pkg and traffic_light_sequencer.
`default_nettype none
module tls_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire tls_pkg::out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every accepted request yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_cross: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.lamp != tls_pkg::LampRed) == out_data.cross_line
                  && out_data.lamp != 2'd3)
    else $error("lamp and cross line disagree");

  a_bcd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.count_tens <= 4'd9 && out_data.count_units <= 4'd9
                  && (out_data.count_tens != 4'd0 || out_data.count_units != 4'd0))
    else $error("count out of range");

endmodule

bind traffic_light_sequencer tls_checker u_tls_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for traffic_light_sequencer: drives tick requests and APB
// length writes, predicts every display word and compares it. Needs tls_pkg.
module tb_top;

  localparam int QuietLimit     = 5000;
  localparam int PressureCycles = 400;

  // Predicts the lamp and countdown shown after each tick and checks the block.
  class signal_scoreboard;
    tls_pkg::len_t lengths [tls_pkg::NumRegs];
    logic [2:0]    phase;
    tls_pkg::len_t remaining;
    logic          long_mode;
    logic [2:0]    resume_phase;
    tls_pkg::out_t expected_display [$];
    int            mismatches;

    function new();
      lengths      = '{7'd30, 7'd66, 7'd66, 7'd3, 7'd8, 7'd20, 7'd30, 7'd30};
      phase        = tls_pkg::PhStart;
      remaining    = '0;
      long_mode    = 1'b0;
      resume_phase = tls_pkg::PhStart;
      mismatches   = 0;
    endfunction

    // Zero counts as one tick, anything past the display range saturates.
    function tls_pkg::len_t length_of(logic [2:0] idx);
      tls_pkg::len_t v;
      v = lengths[idx];
      if (v == 7'd0) v = 7'd1;
      if (v > tls_pkg::MaxCount) v = tls_pkg::MaxCount;
      return v;
    endfunction

    function void enter(logic [2:0] ph);
      logic [2:0] idx;
      phase = ph;
      case (ph)
        tls_pkg::PhGreen:
          idx = long_mode ? tls_pkg::RegGreenSensor : tls_pkg::RegGreenNormal;
        tls_pkg::PhAmber:    idx = tls_pkg::RegAmberNormal;
        tls_pkg::PhRed:
          idx = long_mode ? tls_pkg::RegRedSensor : tls_pkg::RegRedNormal;
        tls_pkg::PhReqLead:  idx = tls_pkg::RegRequestHold;
        tls_pkg::PhReqGreen: idx = tls_pkg::RegGreenRequest;
        tls_pkg::PhReqAmber: idx = tls_pkg::RegRequestHold;
        default:             idx = tls_pkg::RegRedRequest;
      endcase
      remaining = length_of(idx);
    endfunction

    function void start_cycle(logic sensor);
      long_mode = sensor;
      enter(tls_pkg::PhGreen);
    endfunction

    function void note_tick(tls_pkg::in_t t);
      tls_pkg::out_t want;
      if (t.request_edge && phase < tls_pkg::PhReqLead) begin
        if (phase == tls_pkg::PhGreen) resume_phase = tls_pkg::PhAmber;
        else if (phase == tls_pkg::PhAmber) resume_phase = tls_pkg::PhRed;
        else resume_phase = tls_pkg::PhStart;
        // lead with red only when red is already lit
        enter((phase == tls_pkg::PhRed) ? tls_pkg::PhReqLead : tls_pkg::PhReqGreen);
      end else if (phase == tls_pkg::PhStart) begin
        start_cycle(t.sensor_level);
      end else if (remaining > 7'd1) begin
        remaining = remaining - 7'd1;
      end else begin
        case (phase)
          tls_pkg::PhGreen:    enter(tls_pkg::PhAmber);
          tls_pkg::PhAmber:    enter(tls_pkg::PhRed);
          tls_pkg::PhRed:      start_cycle(t.sensor_level);
          tls_pkg::PhReqLead:  enter(tls_pkg::PhReqGreen);
          tls_pkg::PhReqGreen: enter(tls_pkg::PhReqAmber);
          tls_pkg::PhReqAmber: enter(tls_pkg::PhReqRed);
          default: begin
            if (resume_phase == tls_pkg::PhAmber || resume_phase == tls_pkg::PhRed)
              enter(resume_phase);
            else start_cycle(t.sensor_level);
          end
        endcase
      end

      if (phase == tls_pkg::PhGreen || phase == tls_pkg::PhReqGreen)
        want.lamp = tls_pkg::LampGreen;
      else if (phase == tls_pkg::PhAmber || phase == tls_pkg::PhReqAmber)
        want.lamp = tls_pkg::LampAmber;
      else want.lamp = tls_pkg::LampRed;
      want.cross_line      = (want.lamp != tls_pkg::LampRed);
      want.count_tens      = 4'(remaining / 10);
      want.count_units     = 4'(remaining % 10);
      want.serving_request = (phase >= tls_pkg::PhReqLead);
      expected_display.push_back(want);
    endfunction

    function void check_display(tls_pkg::out_t got);
      tls_pkg::out_t want;
      if (expected_display.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: display word with no tick pending: lamp=%0d tens=%0d units=%0d",
                   $realtime, got.lamp, got.count_tens, got.count_units);
        return;
      end
      want = expected_display.pop_front();
      if (got.lamp !== want.lamp || got.cross_line !== want.cross_line ||
          got.count_tens !== want.count_tens || got.count_units !== want.count_units ||
          got.serving_request !== want.serving_request) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp lamp=%0d cr=%0d cnt=%0d%0d rq=%0d, got lamp=%0d cr=%0d %0d%0d rq=%0d",
                   $realtime, want.lamp, want.cross_line, want.count_tens, want.count_units,
                   want.serving_request, got.lamp, got.cross_line, got.count_tens,
                   got.count_units, got.serving_request);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  tls_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  tls_pkg::out_t             out_data;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [tls_pkg::AddrW-1:0] paddr = '0;
  logic [tls_pkg::DataW-1:0] pwdata = '0;
  logic [tls_pkg::DataW-1:0] prdata;
  logic                      pready;

  signal_scoreboard sb = new();
  tls_pkg::len_t    plan [tls_pkg::NumRegs];
  logic             steady = 1'b0;
  logic             hold_off_pending = 1'b0;
  int               quiet_cycles = 0;

  traffic_light_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_tick(logic sensor, logic req);
    int gap;
    int roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 12) gap = 0;
    else if (roll < 19) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sensor_level <= sensor;
    in_data.request_edge <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_tick('{sensor_level: sensor, request_edge: req});
  endtask

  task automatic program_length(logic [2:0] idx, tls_pkg::len_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.lengths[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_plan();
    for (int k = 0; k < tls_pkg::NumRegs; k++) program_length(3'(k), plan[k]);
  endtask

  // Drop valid and wait for every pending display word.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_display.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Advance with plain ticks until the predicted phase is reached, then request.
  task automatic tick_to(logic [2:0] target, logic sensor);
    while (sb.phase != target) send_tick(sensor, 1'b0);
    send_tick(sensor, 1'b1);
  endtask

  task automatic run_random(int count, int req_odds);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) steady = ~steady;
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(1, req_odds) == 1));
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // request before any lamp is lit, lengths still at reset values
    send_tick(1'b1, 1'b1);
    run_random(200, 12);
    settle();

    // short lengths; amber written as zero
    plan = '{7'd2, 7'd3, 7'd2, 7'd0, 7'd2, 7'd1, 7'd3, 7'd1};
    load_plan();
    tick_to(tls_pkg::PhGreen, 1'b0);
    tick_to(tls_pkg::PhReqGreen, 1'b1);
    tick_to(tls_pkg::PhAmber, 1'b1);
    tick_to(tls_pkg::PhRed, 1'b0);
    tick_to(tls_pkg::PhReqLead, 1'b1);
    repeat (4) begin
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
    end
    settle();

    foreach (plan[k]) plan[k] = tls_pkg::len_t'($urandom_range(0, 5));
    load_plan();
    run_random(200, 10);
    hold_off_pending = 1'b1;
    run_random(200, 10);
    settle();

    foreach (plan[k]) plan[k] = '0;
    load_plan();
    run_random(150, 6);
    settle();

    foreach (plan[k])
      plan[k] = ($urandom_range(0, 4) == 0) ? tls_pkg::len_t'($urandom_range(90, 127))
                                            : tls_pkg::len_t'($urandom_range(1, 8));
    load_plan();
    run_random(400, 10);
    settle();

    // top of the range: saturating and exact maximum
    plan = '{7'd127, 7'd99, 7'd127, 7'd99, 7'd127, 7'd99, 7'd127, 7'd99};
    load_plan();
    run_random(300, 40);
    settle();

    foreach (plan[k]) plan[k] = tls_pkg::len_t'($urandom_range(0, 5));
    load_plan();
    run_random(300, 8);
    settle();

    if (sb.mismatches == 0 && sb.expected_display.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int left;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_pending) begin
        // hold off long enough for the block to fill and stall its input
        hold_off_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (PressureCycles) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        repeat ($urandom_range(10, 40)) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
          left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
          out_ready <= 1'b0;
          repeat (left) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_display(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
src/tls_pkg.sv
src/tls_regs.sv
src/tls_seq.sv
src/tls_disp.sv
src/traffic_light_sequencer.sv
src/tls_checker.sv
tb/tb_top.sv
